>>> sv/rstab_pkg.sv
// Shared types and constants for the randomized set table.
// No dependencies; used by rstab_mod and randomized_set_table.
package rstab_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CountWidth = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RANDOM = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

endpackage

>>> sv/rstab_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rstab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rstab_mod.sv
// Iterative restoring modulo unit: one dividend bit per cycle.
// Depends on rstab_pkg for the dividend width.
module rstab_mod #(
  parameter int unsigned DivWidth = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rstab_pkg::DataWidth-1:0]    dividend_i,
  input  logic [DivWidth-1:0]                divisor_i,
  output logic                               done_o,
  output logic [DivWidth-1:0]                rem_o
);

  localparam int unsigned CntW = $clog2(rstab_pkg::DataWidth);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [rstab_pkg::DataWidth-1:0]   dvd_q, dvd_d;
  logic [DivWidth-1:0]               dvs_q, dvs_d;
  logic [DivWidth-1:0]               rem_q, rem_d;
  logic [DivWidth:0]                 trial;
  logic [DivWidth:0]                 diff;

  assign trial = {rem_q, dvd_q[rstab_pkg::DataWidth-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, dvs_q}) ? diff[DivWidth-1:0] : trial[DivWidth-1:0];
      dvd_d = {dvd_q[rstab_pkg::DataWidth-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(rstab_pkg::DataWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/randomized_set_table.sv
// Randomized set table: dense element RAM, linear search, iterative modulo pick.
// Depends on rstab_pkg, rstab_ram and rstab_mod.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   request | in_valid_i/in_ready_o  | op_i, value_i, random_word_i
//   result  | out_valid_o/out_ready_i| status_o, element_o, count_after_o
//
// Insert/remove: one RAM read per cycle over the live entries; remove then
// moves the last element into the freed slot. Random: an iterative modulo of
// the 32-bit random word by the count, then a read of the picked entry.
// The output register frees the engine: a new request is taken while a result
// waits. Reset clears state, count and valid flags; the RAM needs no clearing.
module randomized_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [1:0]                              op_i,
  input  logic signed [rstab_pkg::DataWidth-1:0]  value_i,
  input  logic [rstab_pkg::DataWidth-1:0]         random_word_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [1:0]                              status_o,
  output logic signed [rstab_pkg::DataWidth-1:0]  element_o,
  output logic [rstab_pkg::CountWidth-1:0]        count_after_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = rstab_pkg::DataWidth;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEARCH  = 8'b0000_0010,
    S_REM_RD  = 8'b0000_0100,
    S_REM_WR  = 8'b0000_1000,
    S_MOD     = 8'b0001_0000,
    S_RND_CAP = 8'b0010_0000,
    S_RESP    = 8'b0100_0000,
    S_UNUSED  = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  rstab_pkg::op_e       op_q, op_d;
  logic [DW-1:0]        value_q, value_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]        cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]        pos_q, pos_d;
  rstab_pkg::status_e   res_status_q, res_status_d;
  logic [DW-1:0]        res_elem_q, res_elem_d;
  logic                 out_valid_q, out_valid_d;
  rstab_pkg::status_e   out_status_q, out_status_d;
  logic [DW-1:0]        out_elem_q, out_elem_d;
  logic [rstab_pkg::CountWidth-1:0] out_count_q, out_count_d;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;

  logic                 mod_start;
  logic                 mod_done;
  logic [CW-1:0]        mod_rem;

  logic [CW-1:0]        count_m1;
  logic                 match;
  logic                 in_fire;

  assign count_m1   = count_q - CW'(1);
  assign match      = cmp_vld_q && (ram_rdata == value_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  rstab_ram #(
    .Width (DW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rstab_mod #(
    .DivWidth (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (random_word_i),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    value_d      = value_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_elem_d   = res_elem_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_elem_d   = out_elem_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[IW-1:0];
    mod_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = rstab_pkg::op_e'(op_i);
          value_d      = value_i;
          idx_d        = '0;
          cmp_vld_d    = 1'b0;
          res_status_d = rstab_pkg::ST_DONE;
          res_elem_d   = '0;
          unique case (rstab_pkg::op_e'(op_i)) inside
            rstab_pkg::OP_INSERT, rstab_pkg::OP_REMOVE: begin
              state_d = S_SEARCH;
            end
            rstab_pkg::OP_RANDOM: begin
              if (count_q == '0) begin
                res_status_d = rstab_pkg::ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (match) begin
          pos_d = cmp_idx_q;
          if (op_q == rstab_pkg::OP_INSERT) begin
            res_status_d = rstab_pkg::ST_NOCHANGE;
            state_d      = S_RESP;
          end else begin
            state_d = S_REM_RD;
          end
        end else if (idx_q < count_q) begin
          cmp_idx_d = idx_q[IW-1:0];
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + CW'(1);
        end else begin
          state_d = S_RESP;
          if (op_q == rstab_pkg::OP_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = rstab_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IW-1:0];
              ram_wdata = value_q;
              count_d   = count_q + CW'(1);
            end
          end else begin
            res_status_d = rstab_pkg::ST_NOCHANGE;
          end
        end
      end
      S_REM_RD: begin
        ram_raddr = count_m1[IW-1:0];
        state_d   = S_REM_WR;
      end
      S_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = ram_rdata;
        count_d   = count_m1;
        state_d   = S_RESP;
      end
      S_MOD: begin
        ram_raddr = mod_rem[IW-1:0];
        if (mod_done) begin
          state_d = S_RND_CAP;
        end
      end
      S_RND_CAP: begin
        res_elem_d = ram_rdata;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_elem_d   = res_elem_q;
          out_count_d  = rstab_pkg::CountWidth'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    cmp_idx_q    <= cmp_idx_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_elem_q   <= res_elem_d;
    out_status_q <= out_status_d;
    out_elem_q   <= out_elem_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign element_o     = out_elem_q;
  assign count_after_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("engine idle right after a request");

  a_elem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_q != rstab_pkg::ST_DONE) |-> element_o == '0)
    else $error("element nonzero on a failed request");

  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD)
    else $error("modulo finished outside the random pick");

endmodule

>>> tb/randomized_set_table_checker.sv
// Checker for the randomized set table: watches both channels, predicts each
// result from its own copy of the set and compares status, element and count.
// Depends on rstab_pkg.
module randomized_set_table_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] value_i,
  input  logic [31:0] random_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] element_i,
  input  logic [6:0]  count_after_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rstab_pkg::status_e status;
    logic [31:0]        element;
    logic [6:0]         count_after;
  } set_result_t;

  logic [31:0]  held_values [CAPACITY];
  int unsigned  held_count;
  set_result_t  expected_results [$];
  set_result_t  oldest;
  int           fails = 0;
  int           pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fails++;
    $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
  endtask

  // Updates the held set and returns the result the request should produce.
  function automatic set_result_t apply_request(rstab_pkg::op_e op, logic [31:0] value,
                                                logic [31:0] rand_word);
    set_result_t res;
    int unsigned slot;
    int unsigned i;
    res.status  = rstab_pkg::ST_DONE;
    res.element = '0;
    slot        = held_count;
    for (i = 0; i < held_count; i++) begin
      if (held_values[i] == value && slot == held_count) begin
        slot = i;
      end
    end
    case (op)
      rstab_pkg::OP_INSERT: begin
        if (slot < held_count) begin
          res.status = rstab_pkg::ST_NOCHANGE;
        end else if (held_count >= CAPACITY) begin
          res.status = rstab_pkg::ST_FULL;
        end else begin
          held_values[held_count] = value;
          held_count++;
        end
      end
      rstab_pkg::OP_REMOVE: begin
        if (slot >= held_count) begin
          res.status = rstab_pkg::ST_NOCHANGE;
        end else begin
          held_values[slot] = held_values[held_count - 1];
          held_count--;
        end
      end
      rstab_pkg::OP_RANDOM: begin
        if (held_count == 0) begin
          res.status = rstab_pkg::ST_EMPTY;
        end else begin
          res.element = held_values[rand_word % held_count];
        end
      end
      default: ;
    endcase
    res.count_after = 7'(held_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", element_i, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (status_i !== oldest.status) begin
            report_mismatch("status", 32'(status_i), 32'(oldest.status));
          end
          if (element_i !== oldest.element) begin
            report_mismatch("element", element_i, oldest.element);
          end
          if (count_after_i !== oldest.count_after) begin
            report_mismatch("count_after", 32'(count_after_i), 32'(oldest.count_after));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.insert(expected_results.size(),
                                apply_request(rstab_pkg::op_e'(op_i), value_i,
                                              random_word_i));
      end
      pending <= expected_results.size();
    end
  end

endmodule

>>> tb/randomized_set_table_tb.sv
// Top of the randomized set table testbench: clock, reset, request stimulus
// and result back-pressure; verdict from randomized_set_table_checker.
// Depends on rstab_pkg, randomized_set_table and randomized_set_table_checker.
module randomized_set_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = 64;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          SEGMENTS   = 11;
  localparam int          SEG_ITEMS  = 150;
  localparam int          POOL_SIZE  = 96;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  req_op = rstab_pkg::OP_NOP;
  logic [31:0] req_value = '0;
  logic [31:0] req_random_word = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [1:0]  rsp_status;
  logic [31:0] rsp_element;
  logic [6:0]  rsp_count_after;
  int          fail_count;
  int          pending;

  bit          req_idle_off = 1'b0;
  bit          rsp_idle_off = 1'b0;
  logic [31:0] value_pool [POOL_SIZE];
  logic [31:0] inserted_values [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  randomized_set_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .op_i         (req_op),
    .value_i      (req_value),
    .random_word_i(req_random_word),
    .out_valid_o  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .status_o     (rsp_status),
    .element_o    (rsp_element),
    .count_after_o(rsp_count_after)
  );

  randomized_set_table_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .op_i         (req_op),
    .value_i      (req_value),
    .random_word_i(req_random_word),
    .out_valid_i  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .status_i     (rsp_status),
    .element_i    (rsp_element),
    .count_after_i(rsp_count_after),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_request(rstab_pkg::op_e op, logic [31:0] value,
                              logic [31:0] rand_word);
    int gap;
    gap = req_idle_off ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_op          <= op;
    req_value       <= value;
    req_random_word <= rand_word;
    req_valid       <= 1'b1;
    do @(posedge clk); while (!(req_valid && req_ready));
    if (op == rstab_pkg::OP_INSERT) begin
      inserted_values.insert(inserted_values.size(), value);
    end
  endtask

  function automatic logic [31:0] pick_value(bit for_remove);
    if (for_remove && inserted_values.size() > 0 && $urandom_range(0, 9) < 8) begin
      return inserted_values[$urandom_range(0, inserted_values.size() - 1)];
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom();
    end
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [31:0] pick_random_word();
    return $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200);
  endfunction

  // result back-pressure
  initial begin
    int gap;
    forever begin
      gap = rsp_idle_off ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int             roll;
    bit             filling;
    rstab_pkg::op_e op;
    for (int i = 0; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom();
    end
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, moves of the last element
    send_request(rstab_pkg::OP_RANDOM, 32'h1234_5678, 32'hffff_ffff);
    send_request(rstab_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_NOP,    32'hffff_ffff, 32'hffff_ffff);
    send_request(rstab_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(rstab_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_INSERT, 32'hffff_ffff, 32'h0000_0000);
    send_request(rstab_pkg::OP_INSERT, 32'h7fff_ffff, 32'h0000_0000);
    send_request(rstab_pkg::OP_RANDOM, 32'h0000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_RANDOM, 32'h0000_0000, 32'hffff_ffff);
    send_request(rstab_pkg::OP_RANDOM, 32'hffff_ffff, 32'h0000_0002);
    send_request(rstab_pkg::OP_REMOVE, 32'h1234_5678, 32'h0000_0000);
    send_request(rstab_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0000_0000);
    send_request(rstab_pkg::OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_RANDOM, 32'h0000_0000, 32'h0000_0001);
    send_request(rstab_pkg::OP_NOP,    32'h0000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
    send_request(rstab_pkg::OP_INSERT, 32'haaaa_aaaa, 32'h5555_5555);
    send_request(rstab_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(rstab_pkg::OP_RANDOM, 32'h0000_0000, 32'h8000_0000);
    send_request(rstab_pkg::OP_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
    send_request(rstab_pkg::OP_REMOVE, 32'h5555_5555, 32'h0000_0000);
    send_request(rstab_pkg::OP_REMOVE, 32'haaaa_aaaa, 32'h0000_0000);
    send_request(rstab_pkg::OP_RANDOM, 32'h0000_0000, 32'h0000_0007);

    // random: alternate fill-heavy and drain-heavy segments to reach full and empty
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      filling      = (seg % 2 == 0);
      req_idle_off = (seg % 4 == 3);
      rsp_idle_off = (seg % 4 == 1);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 70 : 15)) begin
          op = rstab_pkg::OP_INSERT;
        end else if (roll < (filling ? 85 : 70)) begin
          op = rstab_pkg::OP_REMOVE;
        end else if (roll < 97) begin
          op = rstab_pkg::OP_RANDOM;
        end else begin
          op = rstab_pkg::OP_NOP;
        end
        send_request(op, pick_value(op == rstab_pkg::OP_REMOVE), pick_random_word());
      end
    end
    req_valid    <= 1'b0;
    rsp_idle_off = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
